[rtl/pcsm_pkg.sv]
// ----------------------------------------------------------------------------
// pcsm_pkg : shared types and constants of the per-channel snr meter
// sequencer states, log2 fraction table and fixed-point constants
// ----------------------------------------------------------------------------
package pcsm_pkg;

   // sequencer of one item
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_NORM,
      ST_INTERP,
      ST_LOG,
      ST_SCALE,
      ST_DONE
   } state_type;

   // one step of the leading-zero search
   typedef struct packed {
      logic [63:0] value;
      logic        hit;
   } norm_type;

   // control strobes from the sequencer
   typedef struct packed {
      logic req_ready;
      logic mem_read;
      logic mem_write;
      logic rsp_load;
   } ctrl_type;

   // log2(1 + i/16) in q1.16
   localparam logic [16:0] LOG2_FRAC_TAB [0:16] = '{
      17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
      17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
      17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
   };

   // 10*log10(2) in q16
   localparam logic [17:0] LOG10_2_Q16 = 18'd197283;

   localparam logic [16:0] SNR_MAX   = 17'h0FFFF;
   localparam logic [16:0] SNR_MIN   = 17'h10000;
   localparam logic [16:0] SNR_MAX_R = 17'd65535;
   localparam logic [16:0] SNR_MIN_R = 17'd65536;

   // six halving steps: 32, 16, 8, 4, 2, 1
   localparam logic [2:0] NORM_LAST = 3'd5;

   localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd1;

endpackage

[rtl/per_channel_snr_meter.sv]
// ----------------------------------------------------------------------------
// per_channel_snr_meter : running snr per channel of an interleaved stream
// reference/test sample pairs, energy sums in a channel memory, log2 snr
// ----------------------------------------------------------------------------
// Each item is a reference and a test sample of one channel; the channel
// comes from a counter that wraps at the programmed channel count (0 acts as
// 1, values above MAX_CHANNELS act as MAX_CHANNELS). Signal and error energy
// of every channel are kept as saturating 64-bit sums in one synchronous
// memory, cleared at reset through a valid bit per entry. Each item yields
// one result: the channel, its running snr in 1/256 dB (q9.8, signed), a
// flag that is low while both sums of the channel are zero, the peak snr and
// the largest positive error seen so far. From acceptance to the next
// acceptance an item goes through memory read, squaring, add and
// write-back, a six-step leading-zero search on both sums, table
// interpolation, difference of the logs, scaling by 10*log10(2) and the final
// rounding. One item is worked on at a time, so the read-modify-write of an
// entry never overlaps another. The result sits in an output register, so a
// new item is taken while the last result still waits on rsp_ready. The
// configuration write is always taken (csr_ready stays high) and is meant to
// be issued while the block is idle.
// ----------------------------------------------------------------------------
module per_channel_snr_meter #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_channel_count,
   // sample items
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_reference_sample,
   input  logic signed [15:0] req_test_sample,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_channel,
   output logic signed [16:0] rsp_channel_snr_db,
   output logic               rsp_snr_valid,
   output logic [15:0]        rsp_peak_snr_db,
   output logic [15:0]        rsp_max_error
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // sequencer
   pcsm_pkg::state_type state_ff, state_in;
   pcsm_pkg::ctrl_type  ctrl;

   // configuration and channel counter
   logic [3:0]      channel_count_ff, channel_count_in;
   logic [CH_W-1:0] counter_ff, counter_in;
   logic [CH_W-1:0] ch_sel;
   int              count_eff;

   // per item working registers
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic signed [15:0] ref_ff, ref_in;
   logic signed [16:0] diff_ff, diff_in;
   logic [31:0]        sig_sq_ff, sig_sq_in;
   logic [31:0]        err_sq_ff, err_sq_in;
   logic signed [31:0] sig_prod;
   logic signed [33:0] err_prod;
   logic [63:0]        s_norm_ff, s_norm_in;
   logic [63:0]        e_norm_ff, e_norm_in;
   logic [5:0]         s_lz_ff, s_lz_in;
   logic [5:0]         e_lz_ff, e_lz_in;
   logic               s_zero_ff, s_zero_in;
   logic               e_zero_ff, e_zero_in;
   logic [2:0]         step_ff, step_in;
   logic [16:0]        s_lo_ff, s_lo_in;
   logic [16:0]        e_lo_ff, e_lo_in;
   logic [12:0]        s_term_ff, s_term_in;
   logic [12:0]        e_term_ff, e_term_in;
   logic               neg_ff, neg_in;
   logic [21:0]        mag_ff, mag_in;
   logic [39:0]        scaled_ff, scaled_in;

   // channel memory: {signal sum, error sum}
   logic [127:0]            mem [MAX_CHANNELS];
   logic [127:0]            rd_data_ff;
   logic                    rd_vld_ff;
   logic [MAX_CHANNELS-1:0] ent_vld_ff, ent_vld_in;
   logic [63:0]             old_s, old_e;
   logic [64:0]             add_s, add_e;
   logic [63:0]             sum_s, sum_e;

   // leading-zero search and interpolation
   pcsm_pkg::norm_type s_step, e_step;
   logic [16:0]        s_lo, s_hi, e_lo, e_hi;
   logic [16:0]        s_delta, e_delta;
   logic [36:0]        s_ip, e_ip;
   logic [22:0]        log_s, log_e, log_d;

   // final result
   logic [40:0]        rounded;
   logic [16:0]        r_mag;
   logic [16:0]        snr_val;
   logic               snr_ok;

   // result register and peaks
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_channel_ff, rsp_channel_in;
   logic [16:0]        rsp_snr_ff, rsp_snr_in;
   logic               rsp_snr_valid_ff, rsp_snr_valid_in;
   logic [15:0]        peak_snr_ff, peak_snr_in;
   logic [15:0]        peak_error_ff, peak_error_in;

   // one halving step of the leading-zero search, shift 32 >> step
   function automatic pcsm_pkg::norm_type norm_step(input logic [63:0] x,
                                                    input logic [2:0] step);
      pcsm_pkg::norm_type res;
      res.value = x;
      res.hit   = 1'b0;
      case (step)
         3'd0: if (x[63:32] == '0) begin res.value = x << 32; res.hit = 1'b1; end
         3'd1: if (x[63:48] == '0) begin res.value = x << 16; res.hit = 1'b1; end
         3'd2: if (x[63:56] == '0) begin res.value = x << 8;  res.hit = 1'b1; end
         3'd3: if (x[63:60] == '0) begin res.value = x << 4;  res.hit = 1'b1; end
         3'd4: if (x[63:62] == '0) begin res.value = x << 2;  res.hit = 1'b1; end
         3'd5: if (x[63] == 1'b0)  begin res.value = x << 1;  res.hit = 1'b1; end
         default: res.hit = 1'b0;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // configuration: the register only, counting goes on from where it was
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      channel_count_in = channel_count_ff;
      if (csr_valid) begin
         channel_count_in = csr_channel_count;
      end
   end

   // effective count 1 .. MAX_CHANNELS, and the channel of the next item
   always_comb begin
      if (channel_count_ff == 4'd0) begin
         count_eff = 1;
      end else if (int'(channel_count_ff) > MAX_CHANNELS) begin
         count_eff = MAX_CHANNELS;
      end else begin
         count_eff = int'(channel_count_ff);
      end
      // counter left beyond a lowered count restarts at channel 0
      ch_sel = (int'(counter_ff) >= count_eff) ? '0 : counter_ff;
      counter_in = counter_ff;
      if (ctrl.req_ready && req_valid) begin
         counter_in = (int'(ch_sel) + 1 >= count_eff) ? '0 : CH_W'(int'(ch_sel) + 1);
      end
   end

   // ------------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         pcsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pcsm_pkg::ST_SQUARE;
            end
         end
         pcsm_pkg::ST_SQUARE: state_in = pcsm_pkg::ST_ACCUM;
         pcsm_pkg::ST_ACCUM: begin
            state_in = pcsm_pkg::ST_NORM;
            step_in  = '0;
         end
         pcsm_pkg::ST_NORM: begin
            if (step_ff == pcsm_pkg::NORM_LAST) begin
               state_in = pcsm_pkg::ST_INTERP;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         pcsm_pkg::ST_INTERP: state_in = pcsm_pkg::ST_LOG;
         pcsm_pkg::ST_LOG:    state_in = pcsm_pkg::ST_SCALE;
         pcsm_pkg::ST_SCALE:  state_in = pcsm_pkg::ST_DONE;
         pcsm_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = pcsm_pkg::ST_IDLE;
            end
         end
         default: state_in = pcsm_pkg::ST_IDLE;
      endcase
   end

   // sequencer: strobes
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         pcsm_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.mem_read  = req_valid;
         end
         pcsm_pkg::ST_ACCUM: ctrl.mem_write = 1'b1;
         pcsm_pkg::ST_DONE:  ctrl.rsp_load  = !rsp_valid_ff || rsp_ready;
         default: ctrl = '0;
      endcase
   end

   assign req_ready = ctrl.req_ready;

   // ------------------------------------------------------------------------
   // channel memory, registered read into rd_data_ff
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ctrl.mem_write) begin
         mem[ch_ff] <= {sum_s, sum_e};
      end
      if (ctrl.mem_read) begin
         rd_data_ff <= mem[ch_sel];
         rd_vld_ff  <= ent_vld_ff[ch_sel];
      end
   end

   always_comb begin
      ent_vld_in = ent_vld_ff;
      if (ctrl.mem_write) begin
         ent_vld_in[ch_ff] = 1'b1;
      end
   end

   // entry never written since reset reads as zero sums
   assign old_s = rd_vld_ff ? rd_data_ff[127:64] : '0;
   assign old_e = rd_vld_ff ? rd_data_ff[63:0]   : '0;
   assign add_s = {1'b0, old_s} + 65'(sig_sq_ff);
   assign add_e = {1'b0, old_e} + 65'(err_sq_ff);
   assign sum_s = add_s[64] ? '1 : add_s[63:0];
   assign sum_e = add_e[64] ? '1 : add_e[63:0];

   // ------------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------------
   assign sig_prod = ref_ff * ref_ff;
   assign err_prod = diff_ff * diff_ff;

   assign s_step = norm_step(s_norm_ff, step_ff);
   assign e_step = norm_step(e_norm_ff, step_ff);

   // table interval from the four bits below the leading one
   assign s_lo    = pcsm_pkg::LOG2_FRAC_TAB[{1'b0, s_norm_ff[62:59]}];
   assign s_hi    = pcsm_pkg::LOG2_FRAC_TAB[5'({1'b0, s_norm_ff[62:59]}) + 5'd1];
   assign e_lo    = pcsm_pkg::LOG2_FRAC_TAB[{1'b0, e_norm_ff[62:59]}];
   assign e_hi    = pcsm_pkg::LOG2_FRAC_TAB[5'({1'b0, e_norm_ff[62:59]}) + 5'd1];
   assign s_delta = s_hi - s_lo;
   assign e_delta = e_hi - e_lo;
   assign s_ip    = s_delta[12:0] * s_norm_ff[58:35];
   assign e_ip    = e_delta[12:0] * e_norm_ff[58:35];

   // log2 in q6.16: leading-one position is the inverted zero count
   assign log_s = 23'({~s_lz_ff, 16'd0}) + 23'(s_lo_ff) + 23'(s_term_ff);
   assign log_e = 23'({~e_lz_ff, 16'd0}) + 23'(e_lo_ff) + 23'(e_term_ff);
   assign log_d = log_s - log_e;

   // round half away from zero on the magnitude, then saturate
   assign rounded = 41'(scaled_ff) + 41'(24'h800000);
   assign r_mag   = rounded[40:24];

   always_comb begin
      snr_ok = 1'b1;
      if (s_zero_ff && e_zero_ff) begin
         snr_val = '0;
         snr_ok  = 1'b0;
      end else if (e_zero_ff) begin
         snr_val = pcsm_pkg::SNR_MAX;
      end else if (s_zero_ff) begin
         snr_val = pcsm_pkg::SNR_MIN;
      end else if (neg_ff) begin
         snr_val = (r_mag > pcsm_pkg::SNR_MIN_R) ? pcsm_pkg::SNR_MIN : 17'(-r_mag);
      end else begin
         snr_val = (r_mag > pcsm_pkg::SNR_MAX_R) ? pcsm_pkg::SNR_MAX : r_mag;
      end
   end

   always_comb begin
      ch_in     = ch_ff;
      ref_in    = ref_ff;
      diff_in   = diff_ff;
      sig_sq_in = sig_sq_ff;
      err_sq_in = err_sq_ff;
      s_norm_in = s_norm_ff;
      e_norm_in = e_norm_ff;
      s_lz_in   = s_lz_ff;
      e_lz_in   = e_lz_ff;
      s_zero_in = s_zero_ff;
      e_zero_in = e_zero_ff;
      s_lo_in   = s_lo_ff;
      e_lo_in   = e_lo_ff;
      s_term_in = s_term_ff;
      e_term_in = e_term_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      scaled_in = scaled_ff;
      case (state_ff)
         pcsm_pkg::ST_IDLE: begin
            ch_in   = ch_sel;
            ref_in  = req_reference_sample;
            diff_in = 17'(req_reference_sample) - 17'(req_test_sample);
         end
         pcsm_pkg::ST_SQUARE: begin
            sig_sq_in = sig_prod;
            err_sq_in = err_prod[31:0];
         end
         pcsm_pkg::ST_ACCUM: begin
            s_norm_in = sum_s;
            e_norm_in = sum_e;
            s_zero_in = (sum_s == '0);
            e_zero_in = (sum_e == '0);
            s_lz_in   = '0;
            e_lz_in   = '0;
         end
         pcsm_pkg::ST_NORM: begin
            s_norm_in = s_step.value;
            e_norm_in = e_step.value;
            s_lz_in[pcsm_pkg::NORM_LAST - step_ff] = s_step.hit;
            e_lz_in[pcsm_pkg::NORM_LAST - step_ff] = e_step.hit;
         end
         pcsm_pkg::ST_INTERP: begin
            s_lo_in   = s_lo;
            e_lo_in   = e_lo;
            s_term_in = s_ip[36:24];
            e_term_in = e_ip[36:24];
         end
         pcsm_pkg::ST_LOG: begin
            neg_in = log_d[22];
            mag_in = log_d[22] ? 22'(-log_d) : log_d[21:0];
         end
         pcsm_pkg::ST_SCALE: begin
            scaled_in = mag_ff * pcsm_pkg::LOG10_2_Q16;
         end
         default: begin
            scaled_in = scaled_ff;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // result register and running peaks
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_channel_in   = rsp_channel_ff;
      rsp_snr_in       = rsp_snr_ff;
      rsp_snr_valid_in = rsp_snr_valid_ff;
      peak_snr_in      = peak_snr_ff;
      peak_error_in    = peak_error_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.rsp_load) begin
         // peak only from a valid, positive snr above the stored one
         if (snr_ok && !snr_val[16] && (snr_val[15:0] > peak_snr_ff)) begin
            peak_snr_in = snr_val[15:0];
         end
         if (!diff_ff[16] && (diff_ff[15:0] > peak_error_ff)) begin
            peak_error_in = diff_ff[15:0];
         end
         rsp_valid_in     = 1'b1;
         rsp_channel_in   = 3'(ch_ff);
         rsp_snr_in       = snr_val;
         rsp_snr_valid_in = snr_ok;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_channel_snr_db = rsp_snr_ff;
   assign rsp_snr_valid      = rsp_snr_valid_ff;
   assign rsp_peak_snr_db    = peak_snr_ff;
   assign rsp_max_error      = peak_error_ff;

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pcsm_pkg::ST_IDLE;
         step_ff          <= '0;
         channel_count_ff <= pcsm_pkg::CHANNEL_COUNT_RESET;
         counter_ff       <= '0;
         ent_vld_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         peak_snr_ff      <= '0;
         peak_error_ff    <= '0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         channel_count_ff <= channel_count_in;
         counter_ff       <= counter_in;
         ent_vld_ff       <= ent_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
         peak_snr_ff      <= peak_snr_in;
         peak_error_ff    <= peak_error_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff            <= ch_in;
      ref_ff           <= ref_in;
      diff_ff          <= diff_in;
      sig_sq_ff        <= sig_sq_in;
      err_sq_ff        <= err_sq_in;
      s_norm_ff        <= s_norm_in;
      e_norm_ff        <= e_norm_in;
      s_lz_ff          <= s_lz_in;
      e_lz_ff          <= e_lz_in;
      s_zero_ff        <= s_zero_in;
      e_zero_ff        <= e_zero_in;
      s_lo_ff          <= s_lo_in;
      e_lo_ff          <= e_lo_in;
      s_term_ff        <= s_term_in;
      e_term_ff        <= e_term_in;
      neg_ff           <= neg_in;
      mag_ff           <= mag_in;
      scaled_ff        <= scaled_in;
      rsp_channel_ff   <= rsp_channel_in;
      rsp_snr_ff       <= rsp_snr_in;
      rsp_snr_valid_ff <= rsp_snr_valid_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == pcsm_pkg::ST_SQUARE))
      else $error("accepted item did not start the sequence");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcsm_pkg::ST_DONE && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == pcsm_pkg::ST_DONE))
      else $error("result overwrote a waiting item");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (peak_snr_ff >= $past(peak_snr_ff)))
      else $error("peak snr decreased");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_snr_valid_ff) |-> (rsp_snr_ff == '0))
      else $error("invalid snr not zero");

   a_write_own_entry: assert property (@(posedge clock) disable iff (reset)
      ctrl.mem_write |=> ent_vld_ff[$past(ch_ff)])
      else $error("written entry not marked valid");

endmodule
